// ===== rtl/core/cdvs_pkg.sv =====
package cdvs_pkg;

  localparam int NumChannels = 8;
  localparam int ChW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam logic [31:0] StFloor    = 32'd7;
  localparam logic [31:0] C048       = 32'd2061584302;
  localparam logic [31:0] C0235      = 32'd1009317315;
  localparam logic [31:0] StReset    = 32'd6554;
  localparam logic [31:0] MsReset    = 32'd0;
  localparam logic [17:0] SrReset    = 18'd48000;

  localparam logic signed [63:0] V40Max = 64'sd549755813887;
  localparam logic signed [63:0] V40Min = -64'sd549755813888;
  localparam logic [63:0]        MagCap = 64'h4000_0000_0000_0000;
  localparam logic signed [63:0] Tiny   = 64'sd2;
  localparam logic signed [63:0] I32Max = 64'sd2147483647;
  localparam logic signed [63:0] I32Min = -64'sd2147483648;

  typedef enum logic [1:0] {
    REG_SMOOTH_TIME = 2'd0,
    REG_MAX_SPEED   = 2'd1,
    REG_SAMPLE_RATE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] goal_value;
    logic [2:0]         channel_index;
  } item_t;

  typedef struct packed {
    logic signed [31:0] smoothed_value;
    logic [2:0]         channel_echo;
  } result_t;

  typedef struct packed {
    logic [31:0] smooth_time;
    logic [31:0] max_speed;
    logic [17:0] sample_rate;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic take;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  // (a*b) >> 32 from the full product, saturating at all ones.
  function automatic logic [63:0] mulq_sat(input logic [127:0] prod);
    return (prod[127:96] != 32'd0) ? '1 : prod[95:32];
  endfunction

  function automatic logic [63:0] addsat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return (a < 0) ? 64'(-a) : 64'(a);
  endfunction

  // Signed result of a magnitude product, truncated toward zero and capped.
  function automatic logic signed [63:0] smul_fin(input logic neg, input logic [127:0] prod);
    logic [63:0] p;
    p = mulq_sat(prod);
    if (p > MagCap) p = MagCap;
    return neg ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic signed [63:0] sat40(input logic signed [63:0] v);
    if (v > V40Max) return V40Max;
    if (v < V40Min) return V40Min;
    return v;
  endfunction

endpackage

// ===== rtl/core/cdvs_mul.sv =====
// 64 x 64 multiplier built from one 32 x 32 multiplier over four passes.
module cdvs_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0] a_r, b_r;
  logic [2:0]  cnt;
  logic        busy, ppv;
  logic [63:0] pp, pp_next;
  logic [1:0]  psh;
  logic [31:0] ma, mb;
  logic [127:0] pp_shifted;

  always_comb begin
    ma = cnt[0] ? a_r[63:32] : a_r[31:0];
    mb = cnt[1] ? b_r[63:32] : b_r[31:0];
    pp_next = ma * mb;
    case (psh)
      2'd0:    pp_shifted = 128'(pp);
      2'd3:    pp_shifted = 128'(pp) << 64;
      default: pp_shifted = 128'(pp) << 32;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ppv  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        cnt  <= 3'd0;
        prod <= '0;
        ppv  <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt < 3'd4) begin
          pp  <= pp_next;
          psh <= cnt[1:0];
          ppv <= 1'b1;
          cnt <= cnt + 3'd1;
        end else begin
          ppv <= 1'b0;
        end
        if (ppv) begin
          prod <= prod + pp_shifted;
        end
        if (cnt == 3'd4 && ppv) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/cdvs_div.sv =====
// Unsigned 64 / 64 restoring divider, one quotient bit per cycle.
module cdvs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] rem, d_r;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] rem_sh, diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem, quotient[63]};
    ge     = rem_sh >= {1'b0, d_r};
    diff   = rem_sh - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        d_r      <= divisor;
        cnt      <= 7'd64;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? diff[63:0] : rem_sh[63:0];
        quotient <= {quotient[62:0], ge};
        cnt      <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/cdvs_seq.sv =====
// Sequencer and datapath: steps one channel through the shared multiplier
// and divider, and holds the per-channel value and velocity.
module cdvs_seq (
  input  logic                clk,
  input  logic                rst,
  input  cdvs_pkg::cfg_t      cfg,
  input  cdvs_pkg::item_t     item,
  input  cdvs_pkg::seq_ctl_t  ctl,
  output cdvs_pkg::seq_stat_t stat,
  output cdvs_pkg::result_t   res
);

  localparam int ChW = cdvs_pkg::ChW;

  typedef enum logic [3:0] {
    S_IDLE, S_OMEGA, S_XDIV, S_X2, S_X3, S_DA, S_DB, S_DEC,
    S_LIM, S_M1, S_N5, S_M2, S_M3, S_M4, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic   issued;

  logic signed [31:0] mem_val [cdvs_pkg::NumChannels];
  logic signed [39:0] mem_vel [cdvs_pkg::NumChannels];

  logic signed [31:0] goal;
  logic [2:0]         ch;
  logic [ChW-1:0]     idx;
  logic [63:0]        omega, x, x2, x3, den;
  logic [31:0]        decay;
  logic signed [63:0] cur, vel, n4, n5, t2, n6, tmp;

  logic [31:0]  st;
  logic [17:0]  sr;
  logic         mul_start, div_start, mul_done, div_done, unit_done;
  logic [63:0]  mul_a, mul_b, div_n, div_d, quo;
  logic [127:0] prod;
  logic signed [63:0] n45, diff, lim, cur_in, n6c;

  always_comb begin
    st = (cfg.smooth_time < cdvs_pkg::StFloor) ? cdvs_pkg::StFloor : cfg.smooth_time;
    sr = (cfg.sample_rate == 18'd0) ? 18'd1 : cfg.sample_rate;
    n45 = n4 + n5;
    lim = $signed({8'd0, prod[63:8]});
    diff = cur - 64'(goal);
    if (cfg.max_speed != 32'd0) begin
      if (diff > lim) diff = lim;
      if (diff < -lim) diff = -lim;
    end
    cur_in = 64'(mem_val[ChW'(item.channel_index)]);
    if (cur_in > -cdvs_pkg::Tiny && cur_in < cdvs_pkg::Tiny && item.goal_value == 32'sd0) begin
      cur_in = '0;
    end
    n6c = n6;
    if (vel > -cdvs_pkg::Tiny && vel < cdvs_pkg::Tiny) n6c = t2;
    if (n6c > cdvs_pkg::I32Max) n6c = cdvs_pkg::I32Max;
    if (n6c < cdvs_pkg::I32Min) n6c = cdvs_pkg::I32Min;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = '0;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state)
      S_OMEGA: begin
        div_n = 64'd1 << 49;
        div_d = 64'(st);
        div_start = !issued;
      end
      S_XDIV: begin
        div_n = omega;
        div_d = 64'(sr);
        div_start = !issued;
      end
      S_DEC: begin
        div_n = '1;
        div_d = den;
        div_start = !issued;
      end
      S_N5: begin
        div_n = cdvs_pkg::mag(tmp);
        div_d = 64'(sr);
        div_start = !issued;
      end
      S_X2: begin
        mul_a = x;
        mul_b = x;
        mul_start = !issued;
      end
      S_X3: begin
        mul_a = x2;
        mul_b = x;
        mul_start = !issued;
      end
      S_DA: begin
        mul_a = 64'(cdvs_pkg::C048);
        mul_b = x2;
        mul_start = !issued;
      end
      S_DB: begin
        mul_a = 64'(cdvs_pkg::C0235);
        mul_b = x3;
        mul_start = !issued;
      end
      S_LIM: begin
        mul_a = 64'(cfg.max_speed);
        mul_b = 64'(st);
        mul_start = !issued;
      end
      S_M1: begin
        mul_a = cdvs_pkg::mag(n4);
        mul_b = omega;
        mul_start = !issued;
      end
      S_M2: begin
        mul_a = cdvs_pkg::mag(n45);
        mul_b = 64'(decay);
        mul_start = !issued;
      end
      S_M3: begin
        mul_a = cdvs_pkg::mag(n5);
        mul_b = omega;
        mul_start = !issued;
      end
      S_M4: begin
        mul_a = cdvs_pkg::mag(tmp);
        mul_b = 64'(decay);
        mul_start = !issued;
      end
      default: begin
      end
    endcase
    unit_done = mul_done | div_done;
    stat.idle = (state == S_IDLE);
    stat.done = (state == S_OUT);
  end

  cdvs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  cdvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
      for (int i = 0; i < cdvs_pkg::NumChannels; i++) begin
        mem_val[i] <= '0;
        mem_vel[i] <= '0;
      end
    end else begin
      if (state != S_IDLE && state != S_FIN && state != S_OUT) begin
        if (!issued) issued <= 1'b1;
        else if (unit_done) issued <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            goal <= item.goal_value;
            ch   <= item.channel_index;
            idx  <= ChW'(item.channel_index);
            cur  <= cur_in;
            vel  <= 64'(mem_vel[ChW'(item.channel_index)]);
            if (32'(item.channel_index) < 32'(cdvs_pkg::NumChannels)) begin
              state <= S_OMEGA;
            end else begin
              res   <= '{smoothed_value: '0, channel_echo: item.channel_index};
              state <= S_OUT;
            end
          end
        end
        S_OMEGA: if (issued && unit_done) begin
          omega <= quo;
          state <= S_XDIV;
        end
        S_XDIV: if (issued && unit_done) begin
          x     <= quo;
          state <= S_X2;
        end
        S_X2: if (issued && unit_done) begin
          x2    <= cdvs_pkg::mulq_sat(prod);
          state <= S_X3;
        end
        S_X3: if (issued && unit_done) begin
          x3    <= cdvs_pkg::mulq_sat(prod);
          state <= S_DA;
        end
        S_DA: if (issued && unit_done) begin
          den   <= cdvs_pkg::addsat(64'h1_0000_0000 + x, cdvs_pkg::mulq_sat(prod));
          state <= S_DB;
        end
        S_DB: if (issued && unit_done) begin
          den   <= cdvs_pkg::addsat(den, cdvs_pkg::mulq_sat(prod));
          state <= S_DEC;
        end
        S_DEC: if (issued && unit_done) begin
          decay <= quo[31:0];
          state <= S_LIM;
        end
        S_LIM: if (issued && unit_done) begin
          n4    <= diff;
          state <= S_M1;
        end
        S_M1: if (issued && unit_done) begin
          tmp   <= vel + cdvs_pkg::sat40(cdvs_pkg::smul_fin(n4 < 0, prod));
          t2    <= cur - n4;
          state <= S_N5;
        end
        S_N5: if (issued && unit_done) begin
          n5    <= (tmp < 0) ? -$signed(quo) : $signed(quo);
          state <= S_M2;
        end
        S_M2: if (issued && unit_done) begin
          // Overshoot of the clamped goal snaps and stops the channel.
          if ((n4 < 0) == ((t2 + cdvs_pkg::smul_fin(n45 < 0, prod)) > t2)) begin
            n6    <= t2;
            vel   <= '0;
            state <= S_FIN;
          end else begin
            n6    <= t2 + cdvs_pkg::smul_fin(n45 < 0, prod);
            state <= S_M3;
          end
        end
        S_M3: if (issued && unit_done) begin
          tmp   <= vel - cdvs_pkg::sat40(cdvs_pkg::smul_fin(n5 < 0, prod));
          state <= S_M4;
        end
        S_M4: if (issued && unit_done) begin
          vel   <= cdvs_pkg::sat40(cdvs_pkg::smul_fin(tmp < 0, prod));
          state <= S_FIN;
        end
        S_FIN: begin
          mem_val[idx] <= n6c[31:0];
          mem_vel[idx] <= vel[39:0];
          res   <= '{smoothed_value: n6c[31:0], channel_echo: ch};
          state <= S_OUT;
        end
        S_OUT: begin
          if (ctl.take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/critically_damped_value_smoother.sv =====
// Channel   | Direction | Handshake                  | Payload
// item      | in        | item_valid / item_ready    | cdvs_pkg::item_t (goal, channel)
// result    | out       | result_valid / result_ready| cdvs_pkg::result_t (value, echo)
// cfg       | in        | cfg_valid / cfg_ready      | cfg_index (2 bit), cfg_data (32 bit)
//
// One item passes through four 64-bit divisions in the shared restoring
// divider, nine 64-bit products in the shared 32 x 32 multiplier, and three
// sequencer steps (write-back, hand-over and idle) from acceptance to the
// next acceptance when its result is taken at once. An overshoot skips the
// last two products. An item with a channel index beyond the channel count
// skips the arithmetic and hands over a zero value with its channel echo.
// Reset is synchronous and clears all channel values and velocities to zero
// and loads the register defaults. A finished result waits in the output
// register, and the next item may be accepted while it waits; a second
// finished result stalls the sequencer until the register is emptied.
module critically_damped_value_smoother (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  cdvs_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output cdvs_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  cdvs_pkg::cfg_t      cfg;
  cdvs_pkg::seq_ctl_t  ctl;
  cdvs_pkg::seq_stat_t stat;
  cdvs_pkg::result_t   seq_res;

  // Configuration writes are always taken; they must be issued only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smooth_time <= cdvs_pkg::StReset;
      cfg.max_speed   <= cdvs_pkg::MsReset;
      cfg.sample_rate <= cdvs_pkg::SrReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cdvs_pkg::REG_SMOOTH_TIME: cfg.smooth_time <= cfg_data;
        cdvs_pkg::REG_MAX_SPEED:   cfg.max_speed   <= cfg_data;
        cdvs_pkg::REG_SAMPLE_RATE: cfg.sample_rate <= cfg_data[17:0];
        default: begin
        end
      endcase
    end
  end

  // A new item is taken whenever the sequencer is idle.
  assign item_ready = stat.idle;
  assign ctl.start  = item_valid && stat.idle;
  // The sequencer hands its result over when the output register is free
  // or is being emptied in the same cycle.
  assign ctl.take   = !result_valid || result_ready;

  cdvs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .ctl  (ctl),
    .stat (stat),
    .res  (seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stat.done && ctl.take) begin
      result_valid <= 1'b1;
      result       <= seq_res;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/cdvs_checker.sv =====
module cdvs_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input cdvs_pkg::result_t result
);

  // A stalled result transaction holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // After reset nothing is pending and the block takes input.
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("bad state after reset");

  // An accepted item keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("ready right after accepting an item");

  // A new result only appears when the block was working.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result without work");

endmodule

bind critically_damped_value_smoother cdvs_checker u_cdvs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
